// ===== rtl/core/ilre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilre_pkg
// Shared types, codes and the byte CRC step of the image loader receive engine.
// ----------------------------------------------------------------------------
package ilre_pkg;

   localparam logic [1:0] FUNC_START   = 2'd0;
   localparam logic [1:0] FUNC_BYTE    = 2'd1;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_READY = 3'd1;
   localparam logic [2:0] KIND_HACK  = 3'd2;
   localparam logic [2:0] KIND_CACK  = 3'd3;
   localparam logic [2:0] KIND_NAK   = 3'd4;

   localparam logic [4:0] RC_OK          = 5'd0;
   localparam logic [4:0] RC_BUSY        = 5'd1;
   localparam logic [4:0] RC_MAGIC       = 5'd2;
   localparam logic [4:0] RC_VERSION     = 5'd3;
   localparam logic [4:0] RC_HDR_SIZE    = 5'd4;
   localparam logic [4:0] RC_HDR_CRC     = 5'd5;
   localparam logic [4:0] RC_FLAGS       = 5'd6;
   localparam logic [4:0] RC_BAD_OID     = 5'd7;
   localparam logic [4:0] RC_SIZE        = 5'd8;
   localparam logic [4:0] RC_ALIGN       = 5'd9;
   localparam logic [4:0] RC_RANGE       = 5'd10;
   localparam logic [4:0] RC_ENTRY       = 5'd11;
   localparam logic [4:0] RC_PAYLOAD_CRC = 5'd15;
   localparam logic [4:0] RC_RX_TIMEOUT  = 5'd21;

   localparam logic [2:0] REG_STAGING_BASE = 3'd0;
   localparam logic [2:0] REG_STAGING_SIZE = 3'd1;
   localparam logic [2:0] REG_MAX_SIZE     = 3'd2;
   localparam logic [2:0] REG_REQ_READBACK = 3'd3;
   localparam logic [2:0] REG_MAGIC        = 3'd4;
   localparam logic [2:0] REG_VERSION      = 3'd5;

   localparam logic [31:0] CRC_INIT  = 32'hffffffff;
   localparam logic [31:0] CRC_POLY  = 32'hedb88320;
   localparam logic [4:0]  HCRC_SPAN = 5'd28;
   localparam logic [7:0]  HDR_LEN   = 8'd32;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] address;
      logic [7:0]  write_byte;
      logic [4:0]  result_code;
      logic [31:0] obj_id;
      logic [31:0] detail;
      logic        last;
   } rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/image_loader_receive_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_loader_receive_engine_core
// Byte-stream receiver: header capture and checks, payload writes, CRC-32.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while req_stall is low. Each item is handled
// by combinational logic between the input port and a 4-entry result queue; the
// last payload byte pushes two results (write, then ack or nak), every other item
// at most one. req_stall rises when fewer than two queue slots are free, so the
// input only waits when the result side is stalled. The header CRC is folded one
// byte per cycle over header bytes 0 to 27 as they are accepted; the header checks
// run on the cycle of byte 31.
module image_loader_receive_engine_core
   import ilre_pkg::*;
#(
   parameter int unsigned     DEST_ALIGN   = 4096,
   parameter longint unsigned ABS_MAX_SIZE = 16777216
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_address,
   output logic [7:0]       rsp_write_byte,
   output logic [4:0]       rsp_result_code,
   output logic [31:0]      rsp_obj_id,
   output logic [31:0]      rsp_detail,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [31:0] ALIGN_MASK = 32'(DEST_ALIGN - 1);
   localparam logic [32:0] ABS_MAX    = 33'(ABS_MAX_SIZE);

   // configuration
   logic [31:0] base_ff, size_ff, maxsz_ff, magic_ff;
   logic        reqrb_ff;
   logic [7:0]  ver_ff;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= '0;
         maxsz_ff <= '0;
         reqrb_ff <= 1'b0;
         magic_ff <= '0;
         ver_ff   <= 8'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            REG_STAGING_BASE: base_ff  <= csr_pwdata;
            REG_STAGING_SIZE: size_ff  <= csr_pwdata;
            REG_MAX_SIZE:     maxsz_ff <= csr_pwdata;
            REG_REQ_READBACK: reqrb_ff <= csr_pwdata[0];
            REG_MAGIC:        magic_ff <= csr_pwdata;
            REG_VERSION:      ver_ff   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_STAGING_BASE: csr_prdata = base_ff;
         REG_STAGING_SIZE: csr_prdata = size_ff;
         REG_MAX_SIZE:     csr_prdata = maxsz_ff;
         REG_REQ_READBACK: csr_prdata = {31'd0, reqrb_ff};
         REG_MAGIC:        csr_prdata = magic_ff;
         REG_VERSION:      csr_prdata = {24'd0, ver_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // session state
   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  hcnt_ff, hcnt_in;
   logic [31:0] bcnt_ff, bcnt_in;
   logic [31:0] crc_ff, crc_in;
   logic [7:0]  hdr_ff [32];

   // result queue
   rsp_type     q_ff [4];
   logic [1:0]  wptr_ff, rptr_ff;
   logic [2:0]  cnt_ff, cnt_in;
   logic        accept, pop, hdr_wr;
   rsp_type     r0, r1;
   logic [1:0]  npush;

   assign req_stall = (cnt_ff > 3'd2);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;

   // header fields
   logic [31:0] h_magic, h_oid, h_dest, h_len, h_entry, h_pcrc, h_hcrc, crc_step, bcnt_inc;
   logic [15:0] h_flags;
   logic [32:0] send, oend;
   logic [4:0]  hcode;

   assign h_magic = {hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]};
   assign h_flags = {hdr_ff[7], hdr_ff[6]};
   assign h_oid   = {hdr_ff[11], hdr_ff[10], hdr_ff[9], hdr_ff[8]};
   assign h_dest  = {hdr_ff[15], hdr_ff[14], hdr_ff[13], hdr_ff[12]};
   assign h_len   = {hdr_ff[19], hdr_ff[18], hdr_ff[17], hdr_ff[16]};
   assign h_entry = {hdr_ff[23], hdr_ff[22], hdr_ff[21], hdr_ff[20]};
   assign h_pcrc  = {hdr_ff[27], hdr_ff[26], hdr_ff[25], hdr_ff[24]};
   // byte 31 is still on the input when the check runs
   assign h_hcrc  = {req_data_byte, hdr_ff[30], hdr_ff[29], hdr_ff[28]};
   assign send    = {1'b0, base_ff} + {1'b0, size_ff};
   assign oend    = {1'b0, h_dest} + {1'b0, h_len};
   assign crc_step = crc_byte(crc_ff, req_data_byte);
   assign bcnt_inc = bcnt_ff + 32'd1;

   always_comb begin
      if (h_magic != magic_ff)                                  hcode = RC_MAGIC;
      else if (hdr_ff[4] != ver_ff)                             hcode = RC_VERSION;
      else if (hdr_ff[5] != HDR_LEN)                            hcode = RC_HDR_SIZE;
      else if ((crc_ff ^ CRC_INIT) != h_hcrc)                   hcode = RC_HDR_CRC;
      else if ((h_flags[15:2] != 14'd0) || (h_flags[1] && !h_flags[0])
               || (reqrb_ff && !h_flags[0]))                    hcode = RC_FLAGS;
      else if (h_oid == 32'd0)                                  hcode = RC_BAD_OID;
      else if ((h_len == 32'd0) || (maxsz_ff == 32'd0) || (h_len > maxsz_ff)
               || ({1'b0, h_len} > ABS_MAX))                    hcode = RC_SIZE;
      else if ((h_dest & ALIGN_MASK) != 32'd0)                  hcode = RC_ALIGN;
      else if ((size_ff == 32'd0) || send[32] || oend[32] || (h_dest < base_ff)
               || (oend > send))                                hcode = RC_RANGE;
      else if (h_flags[1] ? (h_entry >= h_len) : (h_entry != 32'd0)) hcode = RC_ENTRY;
      else                                                      hcode = RC_OK;
   end

   always_comb begin
      phase_in = phase_ff;
      hcnt_in  = hcnt_ff;
      bcnt_in  = bcnt_ff;
      crc_in   = crc_ff;
      hdr_wr   = 1'b0;
      npush    = 2'd0;
      r0       = '0;
      r1       = '0;
      r0.last  = 1'b1;
      r1.last  = 1'b1;
      if (accept) begin
         case (req_func)
            FUNC_START: begin
               npush = 2'd1;
               if (phase_ff == PH_PAYLOAD) begin
                  r0.kind        = KIND_NAK;
                  r0.result_code = RC_BUSY;
                  r0.obj_id      = h_oid;
                  r0.detail      = bcnt_ff;
               end else begin
                  phase_in  = PH_HEADER;
                  hcnt_in   = '0;
                  bcnt_in   = '0;
                  crc_in    = CRC_INIT;
                  r0.kind   = KIND_READY;
                  r0.detail = maxsz_ff;
               end
            end
            FUNC_TIMEOUT: begin
               if (phase_ff != PH_IDLE) begin
                  npush          = 2'd1;
                  phase_in       = PH_IDLE;
                  r0.kind        = KIND_NAK;
                  r0.result_code = RC_RX_TIMEOUT;
                  r0.obj_id      = (phase_ff == PH_PAYLOAD) ? h_oid : 32'd0;
                  r0.detail      = bcnt_ff;
               end
            end
            FUNC_BYTE: begin
               if (phase_ff == PH_HEADER) begin
                  hdr_wr  = 1'b1;
                  hcnt_in = hcnt_ff + 5'd1;
                  if (hcnt_ff < HCRC_SPAN) crc_in = crc_step;
                  if (hcnt_ff == 5'd31) begin
                     npush     = 2'd1;
                     r0.obj_id = h_oid;
                     if (hcode != RC_OK) begin
                        phase_in       = PH_IDLE;
                        r0.kind        = KIND_NAK;
                        r0.result_code = hcode;
                        r0.detail      = bcnt_ff;
                     end else begin
                        phase_in  = PH_PAYLOAD;
                        bcnt_in   = '0;
                        crc_in    = CRC_INIT;
                        r0.kind   = KIND_HACK;
                        r0.detail = h_len;
                     end
                  end
               end else if (phase_ff == PH_PAYLOAD) begin
                  crc_in        = crc_step;
                  bcnt_in       = bcnt_inc;
                  npush         = 2'd1;
                  r0.kind       = KIND_WRITE;
                  r0.address    = h_dest + bcnt_ff;
                  r0.write_byte = req_data_byte;
                  r0.obj_id     = h_oid;
                  if (bcnt_inc >= h_len) begin
                     // final byte: write then the verdict
                     npush     = 2'd2;
                     r0.last   = 1'b0;
                     phase_in  = PH_IDLE;
                     r1.obj_id = h_oid;
                     if ((crc_step ^ CRC_INIT) != h_pcrc) begin
                        r1.kind        = KIND_NAK;
                        r1.result_code = RC_PAYLOAD_CRC;
                        r1.detail      = bcnt_inc;
                     end else begin
                        r1.kind   = KIND_CACK;
                        r1.detail = h_pcrc;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      cnt_in = cnt_ff + {1'b0, npush} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hcnt_ff  <= '0;
         bcnt_ff  <= '0;
         crc_ff   <= CRC_INIT;
         cnt_ff   <= '0;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         bcnt_ff  <= bcnt_in;
         crc_ff   <= crc_in;
         cnt_ff   <= cnt_in;
         wptr_ff  <= wptr_ff + npush;
         if (pop) rptr_ff <= rptr_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_wr) hdr_ff[hcnt_ff] <= req_data_byte;
      if (npush != 2'd0) q_ff[wptr_ff] <= r0;
      if (npush == 2'd2) q_ff[wptr_ff + 2'd1] <= r1;
   end

   assign rsp_kind        = q_ff[rptr_ff].kind;
   assign rsp_address     = q_ff[rptr_ff].address;
   assign rsp_write_byte  = q_ff[rptr_ff].write_byte;
   assign rsp_result_code = q_ff[rptr_ff].result_code;
   assign rsp_obj_id      = q_ff[rptr_ff].obj_id;
   assign rsp_detail      = q_ff[rptr_ff].detail;
   assign rsp_last        = q_ff[rptr_ff].last;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("result queue overfilled");
   a_payload_hcnt: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> hcnt_ff == 5'd0)
      else $error("header count not cleared in payload");
   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FUNC_START |=> phase_ff == PH_HEADER || phase_ff == PH_PAYLOAD)
      else $error("start left block idle");

endmodule
`default_nettype wire

// ===== sim/image_loader_receive_engine_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_loader_receive_engine_core_tb
// Self-checking bench for the image loader receive engine: directed rows, then
// random load sessions (good and corrupted headers, payloads, timeouts) with
// random idling on both sides, checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
module image_loader_receive_engine_core_tb
   import ilre_pkg::*;
();

   localparam int          CLK_HI        = 6;
   localparam int          CLK_LO        = 6;
   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          ITEMS_PER_RUN = 1900;
   localparam int          SETTLE        = 10;
   localparam logic [31:0] ALIGN         = 32'd4096;
   localparam longint      ABS_MAX       = 16777216;
   localparam logic [1:0]  FUNC_NONE     = 2'd3;

   typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PAYLOAD} phase_type;

   typedef struct {
      logic [1:0] func;
      logic [7:0] data;
      bit         fixed;
      rsp_type    rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_NONE;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_address;
   logic [7:0]  rsp_write_byte;
   logic [4:0]  rsp_result_code;
   logic [31:0] rsp_obj_id;
   logic [31:0] rsp_detail;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = 5'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // engine state as predicted
   logic [31:0] cfg_base, cfg_size, cfg_max, cfg_magic;
   logic        cfg_readback;
   logic [7:0]  cfg_version;
   phase_type   eng_phase;
   logic [7:0]  eng_hdr [32];
   int          eng_hdr_count;
   logic [31:0] eng_byte_count;
   logic [31:0] eng_crc;

   rsp_type     expected_rsps [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          items_sent = 0;
   int          snd_idle_pct = 0;
   int          rcv_idle_pct = 0;
   int          rcv_hold = 0;

   image_loader_receive_engine_core dut (.*);

   always begin
      #CLK_HI clock = 1'b1;
      #CLK_LO clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver side: random stall plus a single long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rcv_hold > 0) begin
         rsp_stall <= 1'b1;
         rcv_hold  <= rcv_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected transaction kind %0d", rsp_kind);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind expected %0d actual %0d", e.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_address !== e.address) begin
               $error("address expected %h actual %h", e.address, rsp_address);
               fail_count++;
            end
            if (rsp_write_byte !== e.write_byte) begin
               $error("write_byte expected %h actual %h", e.write_byte, rsp_write_byte);
               fail_count++;
            end
            if (rsp_result_code !== e.result_code) begin
               $error("result_code expected %0d actual %0d", e.result_code,
                      rsp_result_code);
               fail_count++;
            end
            if (rsp_obj_id !== e.obj_id) begin
               $error("obj_id expected %h actual %h", e.obj_id, rsp_obj_id);
               fail_count++;
            end
            if (rsp_detail !== e.detail) begin
               $error("detail expected %h actual %h", e.detail, rsp_detail);
               fail_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 32'hedb88320) : (r >> 1);
      return r;
   endfunction

   function automatic logic [31:0] hdr_word(input int off);
      return {eng_hdr[off + 3], eng_hdr[off + 2], eng_hdr[off + 1], eng_hdr[off]};
   endfunction

   function automatic logic [4:0] judge_header();
      logic [15:0] flags;
      logic [31:0] dest, len, entry, c;
      longint unsigned win_end, obj_end;
      flags   = {eng_hdr[7], eng_hdr[6]};
      dest    = hdr_word(12);
      len     = hdr_word(16);
      entry   = hdr_word(20);
      c       = 32'hffffffff;
      win_end = longint'(cfg_base) + longint'(cfg_size);
      obj_end = longint'(dest) + longint'(len);
      for (int i = 0; i < 28; i++) c = crc_step(c, eng_hdr[i]);
      if (hdr_word(0) != cfg_magic) return RC_MAGIC;
      if (eng_hdr[4] != cfg_version) return RC_VERSION;
      if (eng_hdr[5] != 8'd32) return RC_HDR_SIZE;
      if (~c != hdr_word(28)) return RC_HDR_CRC;
      if (flags[15:2] != 0) return RC_FLAGS;
      if (flags[1] && !flags[0]) return RC_FLAGS;
      if (cfg_readback && !flags[0]) return RC_FLAGS;
      if (hdr_word(8) == 0) return RC_BAD_OID;
      if (len == 0 || cfg_max == 0 || len > cfg_max || longint'(len) > ABS_MAX)
         return RC_SIZE;
      if ((dest & (ALIGN - 1)) != 0) return RC_ALIGN;
      if (cfg_size == 0 || win_end > 64'hffffffff) return RC_RANGE;
      if (obj_end > 64'hffffffff) return RC_RANGE;
      if (dest < cfg_base || obj_end > win_end) return RC_RANGE;
      if (flags[1]) begin
         if (entry >= len) return RC_ENTRY;
      end else if (entry != 0) begin
         return RC_ENTRY;
      end
      return RC_OK;
   endfunction

   // advances the predicted engine by one accepted transaction
   task automatic advance_engine(input logic [1:0] f, input logic [7:0] b);
      rsp_type r;
      logic [4:0] code;
      r = '0;
      r.last = 1'b1;
      case (f)
         FUNC_START: begin
            if (eng_phase == PH_PAYLOAD) begin
               r.kind        = KIND_NAK;
               r.result_code = RC_BUSY;
               r.obj_id      = hdr_word(8);
               r.detail      = eng_byte_count;
            end else begin
               foreach (eng_hdr[i]) eng_hdr[i] = 8'd0;
               eng_hdr_count  = 0;
               eng_byte_count = 0;
               eng_phase      = PH_HEADER;
               r.kind         = KIND_READY;
               r.detail       = cfg_max;
            end
            expected_rsps.push_back(r);
         end
         FUNC_TIMEOUT: begin
            if (eng_phase != PH_IDLE) begin
               r.kind        = KIND_NAK;
               r.result_code = RC_RX_TIMEOUT;
               r.obj_id      = (eng_phase == PH_PAYLOAD) ? hdr_word(8) : 32'd0;
               r.detail      = eng_byte_count;
               eng_phase     = PH_IDLE;
               expected_rsps.push_back(r);
            end
         end
         FUNC_BYTE: begin
            if (eng_phase == PH_HEADER) begin
               eng_hdr[eng_hdr_count] = b;
               eng_hdr_count++;
               if (eng_hdr_count == 32) begin
                  eng_hdr_count = 0;
                  code = judge_header();
                  r.obj_id = hdr_word(8);
                  if (code != RC_OK) begin
                     eng_phase     = PH_IDLE;
                     r.kind        = KIND_NAK;
                     r.result_code = code;
                     r.detail      = eng_byte_count;
                  end else begin
                     eng_byte_count = 0;
                     eng_crc        = 32'hffffffff;
                     eng_phase      = PH_PAYLOAD;
                     r.kind         = KIND_HACK;
                     r.detail       = hdr_word(16);
                  end
                  expected_rsps.push_back(r);
               end
            end else if (eng_phase == PH_PAYLOAD) begin
               r.kind       = KIND_WRITE;
               r.address    = hdr_word(12) + eng_byte_count;
               r.write_byte = b;
               r.obj_id     = hdr_word(8);
               eng_crc        = crc_step(eng_crc, b);
               eng_byte_count = eng_byte_count + 1;
               if (eng_byte_count < hdr_word(16)) begin
                  expected_rsps.push_back(r);
               end else begin
                  r.last = 1'b0;
                  expected_rsps.push_back(r);
                  r = '0;
                  r.last      = 1'b1;
                  r.obj_id    = hdr_word(8);
                  eng_phase   = PH_IDLE;
                  if (~eng_crc != hdr_word(24)) begin
                     r.kind        = KIND_NAK;
                     r.result_code = RC_PAYLOAD_CRC;
                     r.detail      = eng_byte_count;
                  end else begin
                     r.kind   = KIND_CACK;
                     r.detail = hdr_word(24);
                  end
                  expected_rsps.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic [1:0] f, input logic [7:0] b, input bit fixed,
                            input rsp_type e);
      int n0;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n0 = expected_rsps.size();
      advance_engine(f, b);
      if (fixed && expected_rsps.size() > n0) expected_rsps[n0] = e;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_STAGING_BASE: cfg_base     = val;
         REG_STAGING_SIZE: cfg_size     = val;
         REG_MAX_SIZE:     cfg_max      = val;
         REG_REQ_READBACK: cfg_readback = val[0];
         REG_MAGIC:        cfg_magic    = val;
         REG_VERSION:      cfg_version  = val[7:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input int sel);
      drain();
      case (sel % 5)
         0: begin
            csr_write(REG_STAGING_BASE, 32'h0001_0000);
            csr_write(REG_STAGING_SIZE, 32'h0010_0000);
            csr_write(REG_MAX_SIZE, 32'h0000_1000);
            csr_write(REG_REQ_READBACK, 32'd0);
            csr_write(REG_MAGIC, $urandom());
            csr_write(REG_VERSION, 32'd1);
         end
         1: begin
            csr_write(REG_STAGING_BASE, 32'hffef_f000);
            csr_write(REG_STAGING_SIZE, 32'h0010_0fff);
            csr_write(REG_MAX_SIZE, 32'hffff_ffff);
            csr_write(REG_REQ_READBACK, 32'd1);
            csr_write(REG_MAGIC, 32'hffff_ffff);
            csr_write(REG_VERSION, 32'd255);
         end
         2: begin
            csr_write(REG_STAGING_BASE, 32'd0);
            csr_write(REG_STAGING_SIZE, 32'hffff_ffff);
            csr_write(REG_MAX_SIZE, 32'h0100_0000);
            csr_write(REG_REQ_READBACK, 32'd0);
            csr_write(REG_MAGIC, 32'd0);
            csr_write(REG_VERSION, 32'd0);
         end
         3: begin
            csr_write(REG_STAGING_BASE, $urandom() & 32'hfff0_0000);
            csr_write(REG_STAGING_SIZE, $urandom_range(32'h0004_0000, 1));
            csr_write(REG_MAX_SIZE, $urandom_range(30, 1));
            csr_write(REG_REQ_READBACK, $urandom_range(1));
            csr_write(REG_MAGIC, $urandom());
            csr_write(REG_VERSION, $urandom_range(255));
         end
         default: begin
            // empty window rejects every object
            csr_write(REG_STAGING_BASE, $urandom());
            csr_write(REG_STAGING_SIZE, 32'd0);
            csr_write(REG_MAX_SIZE, $urandom_range(64, 1));
            csr_write(REG_REQ_READBACK, 32'd0);
            csr_write(REG_MAGIC, $urandom());
            csr_write(REG_VERSION, $urandom_range(255));
         end
      endcase
   endtask

   task automatic push_word(ref logic [9:0] s [$], input logic [31:0] w);
      for (int i = 0; i < 4; i++) s.push_back({FUNC_BYTE, w[8*i +: 8]});
   endtask

   // one load session, mostly well formed, otherwise broken in one way
   task automatic run_session();
      logic [9:0]  s [$];
      logic [31:0] magic, oid, dest, len, entry, pcrc, hcrc, lim;
      logic [7:0]  ver, hsize;
      logic [15:0] flags;
      logic [7:0]  pay [$];
      longint unsigned a, win_end, room;
      int          mode, cut, nsend;
      rsp_type     none;
      none  = '0;
      mode  = ($urandom_range(99) < 65) ? 0 : $urandom_range(15, 1);
      magic = cfg_magic;
      ver   = cfg_version;
      hsize = 8'd32;
      oid   = $urandom_range(32'hffff_ffff, 1);
      lim   = (cfg_max == 0) ? 1 : ((cfg_max < 24) ? cfg_max : 24);
      len   = $urandom_range(lim, 1);
      a       = (longint'(cfg_base) + 4095) & ~64'hfff;
      win_end = longint'(cfg_base) + longint'(cfg_size);
      if (a + len <= win_end) begin
         room = (win_end - len - a) / 4096;
         if (room > 64) room = 64;
         dest = 32'(a + 4096 * $urandom_range(int'(room)));
      end else begin
         dest = a[31:0];
      end
      flags[0]    = cfg_readback ? 1'b1 : 1'($urandom_range(1));
      flags[1]    = flags[0] ? 1'($urandom_range(1)) : 1'b0;
      flags[15:2] = '0;
      entry = flags[1] ? $urandom_range(len - 1) : 32'd0;
      for (int i = 0; i < len; i++) pay.push_back(8'($urandom_range(255)));
      pcrc = 32'hffffffff;
      foreach (pay[i]) pcrc = crc_step(pcrc, pay[i]);
      pcrc = ~pcrc;
      case (mode)
         1: magic ^= 32'd1 << $urandom_range(31);
         2: ver    = ver + 8'($urandom_range(255, 1));
         3: hsize  = 8'd32 ^ 8'($urandom_range(255, 1));
         5: if ($urandom_range(1)) flags[$urandom_range(15, 2)] = 1'b1;
            else flags[1:0] = 2'b10;
         6: oid = 32'd0;
         7: case ($urandom_range(2))
               0: len = 32'd0;
               1: len = cfg_max + 1;
               default: len = 32'h0100_0001;
            endcase
         8: dest |= 32'd1 << $urandom_range(11);
         9: dest = $urandom_range(1) ? dest - ALIGN : (dest + cfg_size) & ~(ALIGN - 1);
         10: entry = flags[1] ? len + $urandom_range(7) : $urandom_range(255, 1);
         11: pcrc ^= 32'd1 << $urandom_range(31);
         default: ;
      endcase
      if ($urandom_range(9) == 0) s.push_back({FUNC_NONE, 8'($urandom())});
      if ($urandom_range(9) == 0) s.push_back({FUNC_BYTE, 8'($urandom())});
      if ($urandom_range(9) == 0) s.push_back({FUNC_TIMEOUT, 8'($urandom())});
      s.push_back({FUNC_START, 8'($urandom())});
      push_word(s, magic);
      s.push_back({FUNC_BYTE, ver});
      s.push_back({FUNC_BYTE, hsize});
      s.push_back({FUNC_BYTE, flags[7:0]});
      s.push_back({FUNC_BYTE, flags[15:8]});
      push_word(s, oid);
      push_word(s, dest);
      push_word(s, len);
      push_word(s, entry);
      push_word(s, pcrc);
      hcrc = 32'hffffffff;
      for (int i = s.size() - 28; i < s.size(); i++) hcrc = crc_step(hcrc, s[i][7:0]);
      hcrc = ~hcrc;
      if (mode == 4) hcrc ^= 32'd1 << $urandom_range(31);
      push_word(s, hcrc);
      if (mode == 15) begin
         for (int i = s.size() - 32; i < s.size(); i++) s[i][7:0] = 8'($urandom());
      end
      nsend = (len > 24 || len == 0) ? $urandom_range(4) : int'(len);
      foreach (pay[i]) if (i < nsend) s.push_back({FUNC_BYTE, pay[i]});
      cut = $urandom_range(s.size() - 1, 1);
      if (mode == 12) begin
         while (s.size() > cut) void'(s.pop_back());
         s.push_back({FUNC_TIMEOUT, 8'($urandom())});
      end else if (mode == 13 && s.size() > 34) begin
         s.insert($urandom_range(s.size() - 1, 34), {FUNC_START, 8'($urandom())});
      end else if (mode == 14) begin
         s.insert($urandom_range(32, 2), {FUNC_START, 8'($urandom())});
      end
      foreach (s[i]) send_item(s[i][9:8], s[i][7:0], 1'b0, none);
   endtask

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      logic [7:0] hb [32];
      logic [31:0] c;
      int sessions;
      int cfg_sel;
      int phase_items;

      cfg_base = 0; cfg_size = 0; cfg_max = 0; cfg_magic = 0;
      cfg_readback = 0; cfg_version = 8'd1;
      eng_phase = PH_IDLE; eng_hdr_count = 0; eng_byte_count = 0;
      eng_crc = 32'hffffffff;
      foreach (eng_hdr[i]) eng_hdr[i] = 8'd0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows at the reset settings
      row = '{FUNC_TIMEOUT, 8'h00, 1'b0, '0};
      rows.push_back(row);
      row = '{FUNC_BYTE, 8'hff, 1'b0, '0};
      rows.push_back(row);
      row = '{FUNC_NONE, 8'hff, 1'b0, '0};
      rows.push_back(row);
      row = '{FUNC_START, 8'h00, 1'b1, '{KIND_READY, 0, 0, RC_OK, 0, 0, 1'b1}};
      rows.push_back(row);
      row = '{FUNC_BYTE, 8'h00, 1'b0, '0};
      rows.push_back(row);
      row = '{FUNC_TIMEOUT, 8'hff, 1'b1, '{KIND_NAK, 0, 0, RC_RX_TIMEOUT, 0, 0, 1'b1}};
      rows.push_back(row);
      row = '{FUNC_START, 8'hff, 1'b1, '{KIND_READY, 0, 0, RC_OK, 0, 0, 1'b1}};
      rows.push_back(row);
      // well-formed header, but the zero size limit after reset rejects it
      foreach (hb[i]) hb[i] = 8'd0;
      hb[4] = 8'd1; hb[5] = 8'd32;
      {hb[11], hb[10], hb[9], hb[8]}     = 32'h1234_5678;
      {hb[19], hb[18], hb[17], hb[16]}   = 32'd1;
      c = 32'hffffffff;
      for (int i = 0; i < 28; i++) c = crc_step(c, hb[i]);
      {hb[31], hb[30], hb[29], hb[28]} = ~c;
      for (int i = 0; i < 31; i++) begin
         row = '{FUNC_BYTE, hb[i], 1'b0, '0};
         rows.push_back(row);
      end
      row = '{FUNC_BYTE, hb[31], 1'b1,
              '{KIND_NAK, 0, 0, RC_SIZE, 32'h1234_5678, 0, 1'b1}};
      rows.push_back(row);
      foreach (rows[i]) send_item(rows[i].func, rows[i].data, rows[i].fixed, rows[i].rsp);

      sessions = 0;
      cfg_sel  = 0;
      for (int p = 0; p < 3; p++) begin
         snd_idle_pct = (p == 0) ? 26 : (p == 1) ? 74 : 0;
         rcv_idle_pct = (p == 0) ? 74 : (p == 1) ? 26 : 0;
         phase_items  = items_sent;
         while (items_sent - phase_items < ITEMS_PER_RUN / 3) begin
            if (sessions % 6 == 0) begin
               load_config(cfg_sel);
               cfg_sel++;
            end
            // long receiver hold-off while the sender keeps going
            if (p == 0 && sessions == 3) rcv_hold = 300;
            run_session();
            sessions++;
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
